[hw/rtl/sorted_store_occurrence_count_defines.svh]
// Assertion macros for the sorted store occurrence counter.
`ifndef SORTED_STORE_OCCURRENCE_COUNT_DEFINES_SVH
`define SORTED_STORE_OCCURRENCE_COUNT_DEFINES_SVH

// Check that cons holds in the same cycle as ante.
`define SSOC_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Check that cons holds in the cycle after ante.
`define SSOC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

[hw/rtl/ssoc_pkg.sv]
// Shared constants, codes and controller/datapath interface types.
package ssoc_pkg;

    localparam int STORE_DEPTH = 1024;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);
    localparam int CNT_W       = $clog2(STORE_DEPTH + 1);
    localparam int VAL_W       = 32;
    localparam int OCC_W       = 11;
    localparam int POS_W       = 10;

    typedef enum logic [1:0] {
        OP_CLEAR  = 2'd0,
        OP_APPEND = 2'd1,
        OP_QUERY  = 2'd2
    } t_op;

    typedef struct packed {
        logic do_clear;
        logic do_append;
        logic load_query;
        logic probe;
        logic compare;
        logic start_last;
        logic load_out;
    } t_cmd;

    typedef struct packed {
        logic range_open;
        logic hit;
        logic phase_last;
        logic out_free;
    } t_sts;

endpackage

[hw/rtl/ssoc_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
module ssoc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

[hw/rtl/ssoc_ctrl.sv]
// Controller state machine: sequences the two binary searches of a query.
module ssoc_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    input  logic [1:0]    i_operation,
    output logic          o_in_stall,
    input  ssoc_pkg::t_sts i_sts,
    output ssoc_pkg::t_cmd o_cmd
);
    import ssoc_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_TEST = 4'b0010,
        S_CMP  = 4'b0100,
        S_FIN  = 4'b1000
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   w_accept;

    assign o_in_stall = (r_state != S_IDLE);
    assign w_accept   = i_in_valid && (r_state == S_IDLE);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    unique case (i_operation)
                        OP_CLEAR:  o_cmd.do_clear = 1'b1;
                        OP_APPEND: o_cmd.do_append = 1'b1;
                        OP_QUERY: begin
                            o_cmd.load_query = 1'b1;
                            n_state          = S_TEST;
                        end
                        default: ;
                    endcase
                end
            end
            S_TEST: begin
                // open range: read the midpoint; closed range: search is done
                if (i_sts.range_open) begin
                    o_cmd.probe = 1'b1;
                    n_state     = S_CMP;
                end else if (i_sts.hit && !i_sts.phase_last) begin
                    o_cmd.start_last = 1'b1;
                end else begin
                    n_state = S_FIN;
                end
            end
            S_CMP: begin
                o_cmd.compare = 1'b1;
                n_state       = S_TEST;
            end
            S_FIN: begin
                if (i_sts.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end
endmodule

[hw/rtl/ssoc_dp.sv]
// Datapath: element store, fill count, search bounds and result register.
`include "sorted_store_occurrence_count_defines.svh"

module ssoc_dp (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  ssoc_pkg::t_cmd                    i_cmd,
    output ssoc_pkg::t_sts                    o_sts,
    input  logic signed [ssoc_pkg::VAL_W-1:0] i_value,
    input  logic                              i_out_stall,
    output logic                              o_out_valid,
    output logic [ssoc_pkg::OCC_W-1:0]        o_occurrences,
    output logic [ssoc_pkg::POS_W-1:0]        o_first_position,
    output logic                              o_found
);
    import ssoc_pkg::*;

    logic [CNT_W-1:0]         r_fill, n_fill;
    logic [CNT_W-1:0]         r_lo, n_lo;
    logic [CNT_W-1:0]         r_hi, n_hi;
    logic [ADDR_W-1:0]        r_mid, n_mid;
    logic [ADDR_W-1:0]        r_first, n_first;
    logic [ADDR_W-1:0]        r_last, n_last;
    logic                     r_hit, n_hit;
    logic                     r_phase_last, n_phase_last;
    logic signed [VAL_W-1:0]  r_target, n_target;
    logic                     r_out_valid, n_out_valid;
    logic [OCC_W-1:0]         r_occ, n_occ;
    logic [POS_W-1:0]         r_pos, n_pos;
    logic                     r_found, n_found;

    logic [CNT_W-1:0]         w_mid;
    logic [VAL_W-1:0]         w_rdata;
    logic [CNT_W-1:0]         w_span;
    logic                     w_can_append;

    assign w_mid        = r_lo + ((r_hi - r_lo) >> 1);
    assign w_can_append = (r_fill < CNT_W'(STORE_DEPTH));
    assign w_span       = CNT_W'(r_last) - CNT_W'(r_first) + CNT_W'(1);

    ssoc_ram #(
        .WIDTH (VAL_W),
        .DEPTH (STORE_DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (i_cmd.do_append && w_can_append),
        .i_waddr (r_fill[ADDR_W-1:0]),
        .i_wdata (i_value),
        .i_re    (i_cmd.probe),
        .i_raddr (w_mid[ADDR_W-1:0]),
        .o_rdata (w_rdata)
    );

    always_comb begin
        n_fill       = r_fill;
        n_lo         = r_lo;
        n_hi         = r_hi;
        n_mid        = r_mid;
        n_first      = r_first;
        n_last       = r_last;
        n_hit        = r_hit;
        n_phase_last = r_phase_last;
        n_target     = r_target;
        n_occ        = r_occ;
        n_pos        = r_pos;
        n_found      = r_found;
        n_out_valid  = r_out_valid && i_out_stall;

        if (i_cmd.do_clear) begin
            n_fill = '0;
        end
        if (i_cmd.do_append && w_can_append) begin
            n_fill = r_fill + CNT_W'(1);
        end
        if (i_cmd.load_query) begin
            n_lo         = '0;
            n_hi         = r_fill;
            n_hit        = 1'b0;
            n_phase_last = 1'b0;
            n_first      = '0;
            n_target     = i_value;
        end
        if (i_cmd.probe) begin
            n_mid = w_mid[ADDR_W-1:0];
        end
        if (i_cmd.compare) begin
            priority if ($signed(w_rdata) == r_target) begin
                n_hit = 1'b1;
                if (r_phase_last) begin
                    n_last = r_mid;
                    n_lo   = CNT_W'(r_mid) + CNT_W'(1);
                end else begin
                    n_first = r_mid;
                    n_hi    = CNT_W'(r_mid);
                end
            end else if ($signed(w_rdata) < r_target) begin
                n_lo = CNT_W'(r_mid) + CNT_W'(1);
            end else begin
                n_hi = CNT_W'(r_mid);
            end
        end
        if (i_cmd.start_last) begin
            n_lo         = CNT_W'(r_first);
            n_hi         = r_fill;
            n_last       = r_first;
            n_phase_last = 1'b1;
        end
        if (i_cmd.load_out) begin
            n_out_valid = 1'b1;
            n_found     = r_hit;
            n_occ       = r_hit ? OCC_W'(w_span) : '0;
            n_pos       = r_hit ? POS_W'(r_first) : '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_fill      <= n_fill;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_lo         <= n_lo;
        r_hi         <= n_hi;
        r_mid        <= n_mid;
        r_first      <= n_first;
        r_last       <= n_last;
        r_hit        <= n_hit;
        r_phase_last <= n_phase_last;
        r_target     <= n_target;
        r_occ        <= n_occ;
        r_pos        <= n_pos;
        r_found      <= n_found;
    end

    assign o_sts.range_open = (r_lo < r_hi);
    assign o_sts.hit        = r_hit;
    assign o_sts.phase_last = r_phase_last;
    assign o_sts.out_free   = !r_out_valid || !i_out_stall;

    assign o_out_valid      = r_out_valid;
    assign o_occurrences    = r_occ;
    assign o_first_position = r_pos;
    assign o_found          = r_found;

    `SSOC_ASSERT_NOW(a_cmp_open_range, i_cmd.compare, r_lo < r_hi, "compare on empty range")
    `SSOC_ASSERT_NOW(a_fill_bound, 1'b1, r_fill <= CNT_W'(STORE_DEPTH), "fill count over depth")
    `SSOC_ASSERT_NOW(a_last_after_hit, i_cmd.start_last, r_hit && !r_phase_last, "bad second search")
    `SSOC_ASSERT_NOW(a_miss_zero, r_out_valid && !r_found, r_occ == '0 && r_pos == '0, "miss not zero")
    `SSOC_ASSERT_NEXT(a_load_shows, i_cmd.load_out, r_out_valid, "result word lost")
endmodule

[hw/rtl/sorted_store_occurrence_count.sv]
// Top level of the sorted store occurrence counter.
//
// Input channel (i_in_valid / o_in_stall): one word carries an operation and
// a signed 32-bit value. Clear empties the store, append writes the value at
// the fill position (dropped when the store is full), query counts how many
// stored elements equal the value. Code 3 is dropped. Clear and append give
// no result word and do not stall the input.
// A query runs a lower-bound binary search, then, on a hit, an upper-bound
// search from the first hit to the fill position. Each probe is a registered
// memory read of the midpoint, then a compare. A query holds the input until
// its result is loaded into the output register, so the next word is taken
// after that; each search makes at most ceil(log2(fill + 1)) probes.
// Output channel (o_out_valid / i_out_stall): one word per query with the
// occurrence count, first position and found flag. The result sits in an
// output register, so new words are taken while it waits; a query that ends
// while the previous word is still stalled holds until that word is taken.
// Reset (synchronous, active low) empties the store and drops any pending
// result; no clearing pass is needed since only filled entries are read.
module sorted_store_occurrence_count (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic [1:0]                        i_operation,
    input  logic signed [ssoc_pkg::VAL_W-1:0] i_value,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic [ssoc_pkg::OCC_W-1:0]        o_occurrences,
    output logic [ssoc_pkg::POS_W-1:0]        o_first_position,
    output logic                              o_found
);
    import ssoc_pkg::*;

    t_cmd w_cmd;
    t_sts w_sts;

    // Sequence: decode the word, then step the searches one probe at a time.
    ssoc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_operation (i_operation),
        .o_in_stall  (o_in_stall),
        .i_sts       (w_sts),
        .o_cmd       (w_cmd)
    );

    // Hold the store, the search bounds and the result register.
    ssoc_dp u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (w_cmd),
        .o_sts            (w_sts),
        .i_value          (i_value),
        .i_out_stall      (i_out_stall),
        .o_out_valid      (o_out_valid),
        .o_occurrences    (o_occurrences),
        .o_first_position (o_first_position),
        .o_found          (o_found)
    );
endmodule
